### src/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Types and constants shared by the text console cursor writer modules.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int ATTR_W   = 8;
  localparam int POS_W    = 11;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLANK_ATTRIBUTE      = 1'b0,
    CFG_MIN_BACKSPACE_COLUMN = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  character_code;
    logic [COLOR_W-1:0] foreground;
    logic [COLOR_W-1:0] background;
  } item_t;

  typedef struct packed {
    logic               cell_write;
    logic [POS_W-1:0]   cell_index;
    logic [CHAR_W-1:0]  cell_char;
    logic [ATTR_W-1:0]  cell_attribute;
    logic               screen_clear;
    logic [POS_W-1:0]   cursor_position;
  } result_t;

endpackage

### src/tccw_in_stage.sv
// ----------------------------------------------------------------------------
// tccw_in_stage
// Input register: captures one transaction and hands it on when the
// result register can take the next result.
// ----------------------------------------------------------------------------
module tccw_in_stage
  import tccw_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  assign in_ready  = !valid_r || take;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### src/tccw_cursor.sv
// ----------------------------------------------------------------------------
// tccw_cursor
// Cursor state, backspace limit register and the per-character update:
// cell write, wrap to the next row and clear past the last row.
// ----------------------------------------------------------------------------
module tccw_cursor
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  item_t                 item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output result_t               result
);

  localparam logic [COL_W:0] COL_LIMIT = (COL_W+1)'(COLUMNS);
  localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W+1)'(ROWS);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] min_bs_r;

  logic             is_nl, is_bs, bs_act, wr;
  logic [COL_W:0]   col_a, col_b;
  logic [ROW_W:0]   row_a, row_b;
  logic [COL_W-1:0] idx_col;
  logic             clr;

  function automatic logic [POS_W-1:0] lin_pos(input logic [ROW_W-1:0] r,
                                               input logic [COL_W-1:0] c);
    logic [POS_W+1:0] p;
    p = {{(POS_W+2-ROW_W){1'b0}}, r} * (POS_W+2)'(COLUMNS)
      + {{(POS_W+2-COL_W){1'b0}}, c};
    return p[POS_W-1:0];
  endfunction

  assign is_nl  = (item.character_code == CHAR_NEWLINE);
  assign is_bs  = (item.character_code == CHAR_BACKSPACE);
  assign bs_act = is_bs && (col_r > min_bs_r);

  always_comb begin
    col_a   = {1'b0, col_r};
    row_a   = {1'b0, row_r};
    idx_col = col_r;
    wr      = 1'b0;
    if (is_nl) begin
      col_a = '0;
      row_a = {1'b0, row_r} + 1'b1;
    end else if (is_bs) begin
      if (bs_act) begin
        col_a   = {1'b0, col_r} - 1'b1;
        idx_col = col_r - 1'b1;
        wr      = 1'b1;
      end
    end else begin
      col_a = {1'b0, col_r} + 1'b1;
      wr    = 1'b1;
    end

    col_b = col_a;
    row_b = row_a;
    if (col_a >= COL_LIMIT) begin
      col_b = '0;
      row_b = row_a + 1'b1;
    end
    clr = 1'b0;
    if (row_b >= ROW_LIMIT) begin
      clr   = 1'b1;
      col_b = '0;
      row_b = '0;
    end
    col_nxt = col_b[COL_W-1:0];
    row_nxt = row_b[ROW_W-1:0];
  end

  always_comb begin
    result.cell_write      = wr;
    result.cell_index      = wr ? lin_pos(row_r, idx_col) : '0;
    result.cell_char       = wr ? (bs_act ? CHAR_SPACE : item.character_code) : '0;
    result.cell_attribute  = wr ? {item.background, item.foreground} : '0;
    result.screen_clear    = clr;
    result.cursor_position = lin_pos(row_nxt, col_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (step) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // The blank attribute is applied by the consumer on a clear; nothing
  // here depends on it, so its writes are taken and dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bs_r <= 7'd6;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MIN_BACKSPACE_COLUMN: min_bs_r <= cfg_data[COL_W-1:0];
        CFG_BLANK_ATTRIBUTE:      min_bs_r <= min_bs_r;
        default:                  min_bs_r <= min_bs_r;
      endcase
    end
  end

endmodule

### src/tccw_out_stage.sv
// ----------------------------------------------------------------------------
// tccw_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module tccw_out_stage
  import tccw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  input  logic    out_ready,
  output logic    take,
  output logic    out_valid,
  output result_t out_result
);

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign take      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

### src/text_console_cursor_writer.sv
// ----------------------------------------------------------------------------
// text_console_cursor_writer
// Character console cursor writer: one character in, one result out.
//
// Input channel (in_*): character byte with foreground/background colors.
// Output channel (out_*): optional cell write (index, char, attribute),
// a screen clear flag and the new linear cursor position.
// Config channel (cfg_*): index 0 blank attribute, index 1 minimum
// backspace column; always ready. The user must write it only while the
// block is idle; the block itself does not enforce this.
// Path: a transaction accepted on in_* passes the input register, the cursor
// update step and then the result register before it shows on out_*.
// Throughput: one character per cycle while out_ready holds, set by the
// single cursor update step between the input and result registers.
// When the receiver stalls, the result register holds and the input
// register fills; in_ready drops once both are occupied.
// Reset: cursor goes home, both stages empty, registers back to defaults.
// ----------------------------------------------------------------------------
module text_console_cursor_writer
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CHAR_W-1:0]     in_character_code,
  input  logic [COLOR_W-1:0]    in_foreground,
  input  logic [COLOR_W-1:0]    in_background,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_cell_write,
  output logic [POS_W-1:0]      out_cell_index,
  output logic [CHAR_W-1:0]     out_cell_char,
  output logic [ATTR_W-1:0]     out_cell_attribute,
  output logic                  out_screen_clear,
  output logic [POS_W-1:0]      out_cursor_position,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  item_t   in_item, item;
  logic    item_valid, take, step;
  result_t result, out_result;

  assign in_item.character_code = in_character_code;
  assign in_item.foreground     = in_foreground;
  assign in_item.background     = in_background;
  assign cfg_ready = 1'b1;
  assign step      = item_valid && take;

  tccw_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  tccw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  tccw_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .result     (result),
    .out_ready  (out_ready),
    .take       (take),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  assign out_cell_write      = out_result.cell_write;
  assign out_cell_index      = out_result.cell_index;
  assign out_cell_char       = out_result.cell_char;
  assign out_cell_attribute  = out_result.cell_attribute;
  assign out_screen_clear    = out_result.screen_clear;
  assign out_cursor_position = out_result.cursor_position;

endmodule

### src/tccw_checker.sv
// ----------------------------------------------------------------------------
// tccw_checker
// Port-level checks for the text console cursor writer, bound to the top.
// ----------------------------------------------------------------------------
module tccw_checker
  import tccw_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [CHAR_W-1:0]     in_character_code,
  input logic [COLOR_W-1:0]    in_foreground,
  input logic [COLOR_W-1:0]    in_background,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_cell_write,
  input logic [POS_W-1:0]      out_cell_index,
  input logic [CHAR_W-1:0]     out_cell_char,
  input logic [ATTR_W-1:0]     out_cell_attribute,
  input logic                  out_screen_clear,
  input logic [POS_W-1:0]      out_cursor_position,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_position)
      && $stable(out_cell_write) && $stable(out_cell_index))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cell_write |-> out_cell_index == '0
      && out_cell_char == '0 && out_cell_attribute == '0)
    else $error("cell fields set without a cell write");

  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_screen_clear |-> out_cursor_position == '0)
    else $error("screen clear without cursor home");

endmodule

bind text_console_cursor_writer tccw_checker u_tccw_checker (.*);

### sim/tccw_update_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_update_checker
// Watches the character, result and register channels of the console cursor
// writer. It tracks the cursor on its own, queues the cell update that each
// accepted character should produce, and compares every accepted result with
// the oldest queued update field by field.
// ----------------------------------------------------------------------------
module tccw_update_checker
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [CHAR_W-1:0]     in_character_code,
  input  logic [COLOR_W-1:0]    in_foreground,
  input  logic [COLOR_W-1:0]    in_background,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_cell_write,
  input  logic [POS_W-1:0]      out_cell_index,
  input  logic [CHAR_W-1:0]     out_cell_char,
  input  logic [ATTR_W-1:0]     out_cell_attribute,
  input  logic                  out_screen_clear,
  input  logic [POS_W-1:0]      out_cursor_position,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    updates_outstanding,
  output logic [POS_W-1:0]      last_cursor
);

  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [ATTR_W-1:0] blank_attr;
  logic [COL_W-1:0]  min_bs_col;
  result_t           pending_cell_updates[$];
  int                mismatches = 0;

  assign mismatch_count = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want_v);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want_v);
    mismatches++;
  endtask

  function automatic result_t advance_cursor(input logic [CHAR_W-1:0] code,
                                             input logic [COLOR_W-1:0] fg,
                                             input logic [COLOR_W-1:0] bg);
    result_t upd;
    int      col;
    int      rw;
    col = int'(cursor_col);
    rw  = int'(cursor_row);
    upd = '0;
    if (code == CHAR_NEWLINE) begin
      col = 0;
      rw++;
    end else if (code == CHAR_BACKSPACE) begin
      if (col > int'(min_bs_col)) begin
        col--;
        upd.cell_write     = 1'b1;
        upd.cell_index     = POS_W'(rw * COLUMNS + col);
        upd.cell_char      = CHAR_SPACE;
        upd.cell_attribute = {bg, fg};
      end
    end else begin
      upd.cell_write     = 1'b1;
      upd.cell_index     = POS_W'(rw * COLUMNS + col);
      upd.cell_char      = code;
      upd.cell_attribute = {bg, fg};
      col++;
    end
    if (col >= COLUMNS) begin
      col = 0;
      rw++;
    end
    if (rw >= ROWS) begin
      upd.screen_clear = 1'b1;
      col = 0;
      rw  = 0;
    end
    cursor_col = COL_W'(col);
    cursor_row = ROW_W'(rw);
    upd.cursor_position = POS_W'(int'(cursor_row) * COLUMNS + int'(cursor_col));
    return upd;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      cursor_col = '0;
      cursor_row = '0;
      blank_attr = 8'd10;
      min_bs_col = 7'd6;
      pending_cell_updates.delete();
      last_cursor <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_BLANK_ATTRIBUTE:      blank_attr = cfg_data;
          CFG_MIN_BACKSPACE_COLUMN: min_bs_col = cfg_data[COL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        last_cursor <= out_cursor_position;
        if (pending_cell_updates.size() == 0) begin
          report_mismatch("result with nothing pending", int'(out_cursor_position), -1);
        end else begin
          want = pending_cell_updates.pop_front();
          if (out_cell_write !== want.cell_write)
            report_mismatch("cell_write", int'(out_cell_write), int'(want.cell_write));
          if (out_cell_index !== want.cell_index)
            report_mismatch("cell_index", int'(out_cell_index), int'(want.cell_index));
          if (out_cell_char !== want.cell_char)
            report_mismatch("cell_char", int'(out_cell_char), int'(want.cell_char));
          if (out_cell_attribute !== want.cell_attribute)
            report_mismatch("cell_attribute", int'(out_cell_attribute),
                            int'(want.cell_attribute));
          if (out_screen_clear !== want.screen_clear)
            report_mismatch("screen_clear", int'(out_screen_clear), int'(want.screen_clear));
          if (out_cursor_position !== want.cursor_position)
            report_mismatch("cursor_position", int'(out_cursor_position),
                            int'(want.cursor_position));
        end
      end
      if (in_valid && in_ready)
        pending_cell_updates.push_back(advance_cursor(in_character_code, in_foreground,
                                                      in_background));
    end
    updates_outstanding <= pending_cell_updates.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the text console cursor writer. Drives directed characters
// (color extremes, newline, backspace on both sides of the limit, register
// extremes) and then phases of random text lines, long runs that wrap, runs
// to the last screen cell that force a clear, backspace bursts and runs of
// random bytes, under varying sender gaps and receiver stalls. Results are
// checked by the update checker.
// ----------------------------------------------------------------------------
module tb;
  import tccw_pkg::*;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int PHASE_ITEMS  = 320;
  localparam int TAIL_CYCLES  = 4;
  localparam int CYCLE_LIMIT  = 300000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CHAR_W-1:0]     in_character_code = '0;
  logic [COLOR_W-1:0]    in_foreground = '0;
  logic [COLOR_W-1:0]    in_background = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_cell_write;
  logic [POS_W-1:0]      out_cell_index;
  logic [CHAR_W-1:0]     out_cell_char;
  logic [ATTR_W-1:0]     out_cell_attribute;
  logic                  out_screen_clear;
  logic [POS_W-1:0]      out_cursor_position;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int                    mismatch_count;
  int                    updates_outstanding;
  logic [POS_W-1:0]      last_cursor;

  int                    idle_pct = 0;
  int                    stall_pct = 0;
  int                    chars_sent = 0;
  int                    cycles = 0;

  always #10 clk = ~clk;

  text_console_cursor_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_character_code   (in_character_code),
    .in_foreground       (in_foreground),
    .in_background       (in_background),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cell_write      (out_cell_write),
    .out_cell_index      (out_cell_index),
    .out_cell_char       (out_cell_char),
    .out_cell_attribute  (out_cell_attribute),
    .out_screen_clear    (out_screen_clear),
    .out_cursor_position (out_cursor_position),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  tccw_update_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_update_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_character_code   (in_character_code),
    .in_foreground       (in_foreground),
    .in_background       (in_background),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cell_write      (out_cell_write),
    .out_cell_index      (out_cell_index),
    .out_cell_char       (out_cell_char),
    .out_cell_attribute  (out_cell_attribute),
    .out_screen_clear    (out_screen_clear),
    .out_cursor_position (out_cursor_position),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatch_count      (mismatch_count),
    .updates_outstanding (updates_outstanding),
    .last_cursor         (last_cursor)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] text_byte();
    logic [CHAR_W-1:0] b;
    do
      b = CHAR_W'($urandom_range(255));
    while (b == CHAR_NEWLINE || b == CHAR_BACKSPACE);
    return b;
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] code, input logic [COLOR_W-1:0] fg,
                           input logic [COLOR_W-1:0] bg);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_character_code <= code;
    in_foreground     <= fg;
    in_background     <= bg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input int n);
    repeat (n) send_char(text_byte(), COLOR_W'($urandom_range(15)),
                         COLOR_W'($urandom_range(15)));
  endtask

  task automatic send_ctrl(input logic [CHAR_W-1:0] code, input int n);
    repeat (n) send_char(code, COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)));
  endtask

  // stop sending and wait until every queued update has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (updates_outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // move to the start of the last row, fill it up to the last cell, then force a clear
  task automatic run_to_last_cell();
    int row;
    int col;
    int ending;
    drain();
    row = int'(last_cursor) / COLUMNS;
    col = int'(last_cursor) % COLUMNS;
    if (row < ROWS - 1)
      send_ctrl(CHAR_NEWLINE, ROWS - 1 - row);
    else if (col != 0)
      send_ctrl(CHAR_NEWLINE, ROWS);
    send_text(COLUMNS - 1);
    ending = $urandom_range(2);
    case (ending)
      0: send_text(1);
      1: send_ctrl(CHAR_NEWLINE, 1);
      default: begin
        send_ctrl(CHAR_BACKSPACE, 1);
        send_text(2);
      end
    endcase
  endtask

  initial begin
    int start;
    int kind;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: color extremes, backspace on both sides of the limit
    send_char(8'h00, 4'h0, 4'h0);
    send_char(8'hFF, 4'hF, 4'hF);
    send_char(8'h41, 4'h5, 4'hA);
    send_ctrl(CHAR_BACKSPACE, 1);
    send_ctrl(CHAR_NEWLINE, 1);
    send_text(8);
    send_ctrl(CHAR_BACKSPACE, 3);
    send_ctrl(CHAR_NEWLINE, 1);
    write_reg(CFG_BLANK_ATTRIBUTE, 8'hFF);
    write_reg(CFG_MIN_BACKSPACE_COLUMN, 8'h00);
    send_char(8'h78, 4'h3, 4'hC);
    send_ctrl(CHAR_BACKSPACE, 2);
    write_reg(CFG_BLANK_ATTRIBUTE, 8'h00);
    write_reg(CFG_MIN_BACKSPACE_COLUMN, 8'hFF);
    send_char(8'h79, 4'h9, 4'h6);
    send_ctrl(CHAR_BACKSPACE, 1);
    send_ctrl(CHAR_NEWLINE, 1);

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      case (p)
        0: begin
          write_reg(CFG_BLANK_ATTRIBUTE, CFG_DATA_W'($urandom_range(255)));
          write_reg(CFG_MIN_BACKSPACE_COLUMN, CFG_DATA_W'($urandom_range(COLUMNS - 1)));
        end
        1: begin
          write_reg(CFG_BLANK_ATTRIBUTE, 8'h00);
          write_reg(CFG_MIN_BACKSPACE_COLUMN, 8'h00);
        end
        2: begin
          write_reg(CFG_BLANK_ATTRIBUTE, 8'hFF);
          write_reg(CFG_MIN_BACKSPACE_COLUMN, CFG_DATA_W'(COLUMNS - 1));
        end
        default: begin
          write_reg(CFG_BLANK_ATTRIBUTE, CFG_DATA_W'($urandom_range(255)));
          write_reg(CFG_MIN_BACKSPACE_COLUMN, CFG_DATA_W'($urandom_range(255)));
        end
      endcase
      start = chars_sent;
      run_to_last_cell();
      while (chars_sent - start < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 50) begin
          send_text($urandom_range(30));
          send_ctrl(CHAR_NEWLINE, 1);
        end else if (kind < 68) begin
          send_text($urandom_range(60, 100));
        end else if (kind < 85) begin
          send_text($urandom_range(12));
          send_ctrl(CHAR_BACKSPACE, $urandom_range(1, 12));
        end else if (kind < 97) begin
          repeat ($urandom_range(1, 10))
            send_char(CHAR_W'($urandom_range(255)), COLOR_W'($urandom_range(15)),
                      COLOR_W'($urandom_range(15)));
        end else begin
          run_to_last_cell();
        end
      end
    end

    drain();
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
